/* sv/dssu_pkg.sv */
// Shared constants and codes for the dual stack shared store unit.
`timescale 1ns / 1ps

package dssu_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int LEN_W         = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_A = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_B = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_A  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_B  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LIST_A = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LIST_B = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   // Command kinds handed from the front end to the back end.
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

endpackage

/* sv/dssu_ram.sv */
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module dssu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dssu_queue.sv */
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module dssu_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int QD = dssu_pkg::QUEUE_DEPTH;
   localparam int PW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW = $clog2(QD + 1);

   logic [WIDTH-1:0] slot_ff [QD];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != CW'(QD));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/dssu_front.sv */
// Front end: accepts request words, tracks stack depths, builds commands.
`timescale 1ns / 1ps

module dssu_front #(
   parameter int DEPTH = dssu_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dssu_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [dssu_pkg::WORD_W-1:0]   req_push_value,
   output logic                                 cmd_valid,
   input  logic                                 cmd_ready,
   output logic [2+dssu_pkg::STATUS_W+$clog2(DEPTH)+dssu_pkg::LEN_W+1+dssu_pkg::WORD_W-1:0]
                                                cmd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [1:0]                    kind;
      logic [dssu_pkg::STATUS_W-1:0] status;
      logic [AW-1:0]                 addr;
      logic [dssu_pkg::LEN_W-1:0]    len;
      logic                          down;
      logic [dssu_pkg::WORD_W-1:0]   wdata;
   } cmd_type;

   logic [CW-1:0]          count_a_ff, count_a_in;
   logic [CW-1:0]          count_b_ff, count_b_in;
   logic [CW:0]            sum;
   logic                   full;
   logic                   known;
   logic                   accept;
   cmd_type                cmd;
   logic [dssu_pkg::LEN_W-1:0] len_a, len_b;

   assign sum    = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign full   = (sum >= (CW + 1)'(DEPTH));
   assign known  = (req_func <= dssu_pkg::FUNC_LIST_B);
   assign accept = req_valid && req_ready;

   // Unknown codes are taken and dropped, so ready follows the queue only.
   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid && known;
   assign cmd_data  = cmd;

   assign len_a = (32'(count_a_ff) > 32'(dssu_pkg::MAX_RESULTS)) ?
                  dssu_pkg::LEN_W'(dssu_pkg::MAX_RESULTS) : dssu_pkg::LEN_W'(count_a_ff);
   assign len_b = (32'(count_b_ff) > 32'(dssu_pkg::MAX_RESULTS)) ?
                  dssu_pkg::LEN_W'(dssu_pkg::MAX_RESULTS) : dssu_pkg::LEN_W'(count_b_ff);

   always_comb begin
      cmd.kind   = dssu_pkg::KIND_REPLY;
      cmd.status = dssu_pkg::STATUS_OK;
      cmd.addr   = '0;
      cmd.len    = dssu_pkg::LEN_W'(1);
      cmd.down   = 1'b0;
      cmd.wdata  = req_push_value;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      unique case (req_func)
         dssu_pkg::FUNC_PUSH_A: begin
            if (full) begin
               cmd.status = dssu_pkg::STATUS_OVERFLOW;
            end else begin
               cmd.kind   = dssu_pkg::KIND_WRITE;
               cmd.addr   = AW'(count_a_ff);
               count_a_in = count_a_ff + CW'(1);
            end
         end
         dssu_pkg::FUNC_PUSH_B: begin
            if (full) begin
               cmd.status = dssu_pkg::STATUS_OVERFLOW;
            end else begin
               cmd.kind   = dssu_pkg::KIND_WRITE;
               cmd.addr   = AW'(CW'(DEPTH - 1) - count_b_ff);
               count_b_in = count_b_ff + CW'(1);
            end
         end
         dssu_pkg::FUNC_POP_A: begin
            if (count_a_ff == '0) begin
               cmd.status = dssu_pkg::STATUS_UNDERFLOW;
            end else begin
               cmd.kind   = dssu_pkg::KIND_READ;
               cmd.addr   = AW'(count_a_ff - CW'(1));
               count_a_in = count_a_ff - CW'(1);
            end
         end
         dssu_pkg::FUNC_POP_B: begin
            if (count_b_ff == '0) begin
               cmd.status = dssu_pkg::STATUS_UNDERFLOW;
            end else begin
               cmd.kind   = dssu_pkg::KIND_READ;
               cmd.addr   = AW'(CW'(DEPTH) - count_b_ff);
               count_b_in = count_b_ff - CW'(1);
            end
         end
         dssu_pkg::FUNC_LIST_A: begin
            if (count_a_ff == '0) begin
               cmd.status = dssu_pkg::STATUS_EMPTY;
            end else begin
               cmd.kind = dssu_pkg::KIND_READ;
               cmd.addr = AW'(count_a_ff - CW'(1));
               cmd.len  = len_a;
               cmd.down = 1'b1;
            end
         end
         dssu_pkg::FUNC_LIST_B: begin
            if (count_b_ff == '0) begin
               cmd.status = dssu_pkg::STATUS_EMPTY;
            end else begin
               cmd.kind = dssu_pkg::KIND_READ;
               cmd.addr = AW'(CW'(DEPTH) - count_b_ff);
               cmd.len  = len_b;
            end
         end
         default: begin
            cmd.kind = dssu_pkg::KIND_REPLY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else if (accept) begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

endmodule

/* sv/dssu_back.sv */
// Back end: executes commands against the store and drives the response word.
`timescale 1ns / 1ps

module dssu_back #(
   parameter int DEPTH = dssu_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  logic [2+dssu_pkg::STATUS_W+$clog2(DEPTH)+dssu_pkg::LEN_W+1+dssu_pkg::WORD_W-1:0]
                                                cmd_data,
   output logic                                 wr_en,
   output logic [$clog2(DEPTH)-1:0]             wr_addr,
   output logic [dssu_pkg::WORD_W-1:0]          wr_data,
   output logic [$clog2(DEPTH)-1:0]             rd_addr,
   input  logic [dssu_pkg::WORD_W-1:0]          rd_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dssu_pkg::WORD_W-1:0]   rsp_data_value,
   output logic [dssu_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_last
);

   localparam int AW = $clog2(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [dssu_pkg::STATUS_W-1:0] status;
      logic [AW-1:0]                 addr;
      logic [dssu_pkg::LEN_W-1:0]    len;
      logic                          down;
      logic [dssu_pkg::WORD_W-1:0]   wdata;
   } cmd_type;

   cmd_type                       cmd;
   logic                          state_ff, state_in;
   logic [AW-1:0]                 addr_ff, addr_in, addr_next;
   logic [dssu_pkg::LEN_W-1:0]    left_ff, left_in;
   logic                          down_ff, down_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dssu_pkg::WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [dssu_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          out_free;
   logic                          take;
   logic                          load;

   assign cmd       = cmd_type'(cmd_data);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign addr_next = down_ff ? addr_ff - AW'(1) : addr_ff + AW'(1);

   assign wr_addr = cmd.addr;
   assign wr_data = cmd.wdata;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      down_in       = down_ff;
      load          = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_addr       = cmd.addr;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (cmd.kind)
                  dssu_pkg::KIND_WRITE: begin
                     wr_en         = 1'b1;
                     load          = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = dssu_pkg::STATUS_OK;
                     rsp_last_in   = 1'b1;
                  end
                  dssu_pkg::KIND_READ: begin
                     addr_in  = cmd.addr;
                     left_in  = cmd.len;
                     down_in  = cmd.down;
                     state_in = ST_READ;
                  end
                  default: begin
                     load          = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = cmd.status;
                     rsp_last_in   = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            // Hold the read address while stalled so the RAM output stays put.
            rd_addr = addr_ff;
            if (out_free) begin
               load          = 1'b1;
               rsp_data_in   = rd_data;
               rsp_status_in = dssu_pkg::STATUS_OK;
               rsp_last_in   = (left_ff == dssu_pkg::LEN_W'(1));
               if (left_ff == dssu_pkg::LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = addr_next;
                  addr_in = addr_next;
                  left_in = left_ff - dssu_pkg::LEN_W'(1);
               end
            end
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      down_ff       <= down_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_value = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("store written during a read burst");

   a_read_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (left_ff != '0))
      else $error("read burst with nothing left");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && out_free && left_ff == dssu_pkg::LEN_W'(1))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final burst word not marked last");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != dssu_pkg::STATUS_OK) |-> (rsp_data_ff == '0))
      else $error("error response carries data");

endmodule

/* sv/dual_stack_shared_store_unit.sv */
// Top level of the dual stack shared store unit.
`timescale 1ns / 1ps

// Two stacks in one store of DEPTH words: stack A grows up from entry 0,
// stack B grows down from entry DEPTH-1.
// Request channel (req_*): one word per operation in req_func (push A/B,
// pop A/B, list A/B) with req_push_value used by pushes. Codes 6 and 7 are
// taken and dropped without a response.
// Response channel (rsp_*): one word per push or pop, carrying rsp_status
// (ok, overflow, underflow, empty) and rsp_data_value; a list streams its
// stack from top to bottom, at most 16 words, with rsp_last on the final one.
// Response path: a push or any error response passes through the command queue
// and the response register; a pop and each word of a list also pass through
// the store's registered read. List words then follow one per cycle unless rsp_ready stalls them.
// Throughput: the front end takes one request per cycle while the two-entry
// command queue has room; the back end can take its next command straight after
// a push or error, but a pop or list holds it in its read state until its final word.
// Reset: both stack depths go to zero and the queue empties; store contents
// are left undefined, and no clearing pass is needed.
// Stalls: when rsp_ready is low the response word holds, the back end stops
// and the queue fills, after which req_ready drops.
module dual_stack_shared_store_unit #(
   parameter int DEPTH = dssu_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dssu_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [dssu_pkg::WORD_W-1:0] req_push_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dssu_pkg::WORD_W-1:0] rsp_data_value,
   output logic [dssu_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_last
);

   localparam int AW = $clog2(DEPTH);

   // Command word from the front end; the same layout is declared in both ends.
   typedef struct packed {
      logic [1:0]                    kind;
      logic [dssu_pkg::STATUS_W-1:0] status;
      logic [AW-1:0]                 addr;
      logic [dssu_pkg::LEN_W-1:0]    len;
      logic                          down;
      logic [dssu_pkg::WORD_W-1:0]   wdata;
   } cmd_type;

   logic                         f_cmd_valid, f_cmd_ready;
   cmd_type                      f_cmd;
   logic                         b_cmd_valid, b_cmd_ready;
   cmd_type                      b_cmd;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [dssu_pkg::WORD_W-1:0]  wr_data, rd_data;

   // Classify requests and track both stack depths.
   dssu_front #(.DEPTH(DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .cmd_valid      (f_cmd_valid),
      .cmd_ready      (f_cmd_ready),
      .cmd_data       (f_cmd)
   );

   // Decouple the two ends so each can stall on its own.
   dssu_queue #(.WIDTH($bits(cmd_type))) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_cmd_valid),
      .push_ready (f_cmd_ready),
      .push_data  (f_cmd),
      .pop_valid  (b_cmd_valid),
      .pop_ready  (b_cmd_ready),
      .pop_data   (b_cmd)
   );

   // Execute commands in order against the store.
   dssu_back #(.DEPTH(DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (b_cmd_valid),
      .cmd_ready      (b_cmd_ready),
      .cmd_data       (b_cmd),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_value (rsp_data_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // Shared word store for both stacks.
   dssu_ram #(.WIDTH(dssu_pkg::WORD_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
